[hdl/hsvck_pkg.sv]
package hsvck_pkg;

    localparam int unsigned CH_W  = 8;
    localparam int unsigned NUM_W = 17;

    localparam logic [CH_W-1:0] SV_MIN = 8'd50;
    localparam logic [CH_W-1:0] WHITE  = 8'hFF;

    // hue band limits on the 0..179 scale
    localparam int unsigned H_BLUE_LO  = 85;
    localparam int unsigned H_BLUE_HI  = 130;
    localparam int unsigned H_RED_HI   = 10;
    localparam int unsigned H_RED_LO   = 160;
    localparam int unsigned H_GREEN_LO = 40;
    localparam int unsigned H_GREEN_HI = 84;

    typedef enum logic [1:0] {
        SEL_BLUE  = 2'd0,
        SEL_RED   = 2'd1,
        SEL_GREEN = 2'd2,
        SEL_NONE  = 2'd3
    } sel_t;

    typedef enum logic [1:0] {
        SEC_R = 2'd0,
        SEC_G = 2'd1,
        SEC_B = 2'd2
    } sector_t;

    // hue numerator and band limits, compared as num >= lim or num < lim
    typedef struct packed {
        logic             valid;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  red;
        logic             sv_ok;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] lim_blue_lo;
        logic [NUM_W-1:0] lim_blue_hi;
        logic [NUM_W-1:0] lim_red_hi;
        logic [NUM_W-1:0] lim_red_lo;
        logic [NUM_W-1:0] lim_green_lo;
        logic [NUM_W-1:0] lim_green_hi;
    } metric_t;

endpackage

[hdl/hsvck_core.sv]
module hsvck_core
    import hsvck_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [CH_W-1:0] in_blue,
    input  logic [CH_W-1:0] in_green,
    input  logic [CH_W-1:0] in_red,
    output metric_t         metric
);

    localparam logic [9:0] M_BLUE_LO  = 10'(2 * H_BLUE_LO);
    localparam logic [9:0] M_BLUE_HI  = 10'(2 * (H_BLUE_HI + 1));
    localparam logic [9:0] M_RED_HI   = 10'(2 * (H_RED_HI + 1));
    localparam logic [9:0] M_RED_LO   = 10'(2 * H_RED_LO);
    localparam logic [9:0] M_GREEN_LO = 10'(2 * H_GREEN_LO);
    localparam logic [9:0] M_GREEN_HI = 10'(2 * (H_GREEN_HI + 1));
    localparam logic [9:0] S_NUM      = 10'(2 * 255);
    localparam logic [9:0] S_DEN      = 10'(2 * int'(SV_MIN) - 1);
    localparam logic [6:0] H_SCALE    = 7'd60;

    // stage 1: max, min, spread, sector
    logic                 v1_reg;
    logic [CH_W-1:0]      b1_reg, g1_reg, r1_reg, max1_reg, d1_reg;
    sector_t              sec1_reg;
    logic [CH_W-1:0]      max1_next, min1_next;
    sector_t              sec1_next;

    always_comb
    begin
        max1_next = in_blue;
        min1_next = in_blue;
        if (in_green > max1_next)
        begin
            max1_next = in_green;
        end
        if (in_red > max1_next)
        begin
            max1_next = in_red;
        end
        if (in_green < min1_next)
        begin
            min1_next = in_green;
        end
        if (in_red < min1_next)
        begin
            min1_next = in_red;
        end
        if (max1_next == in_red)
        begin
            sec1_next = SEC_R;
        end
        else if (max1_next == in_green)
        begin
            sec1_next = SEC_G;
        end
        else
        begin
            sec1_next = SEC_B;
        end
    end

    // stage 2: sector offset t, saturation and value tests
    logic                 v2_reg;
    logic [CH_W-1:0]      b2_reg, g2_reg, r2_reg, d2_reg;
    logic [11:0]          t2_reg;
    logic                 sv2_reg;
    logic [11:0]          t_raw, t_adj, d_x6;
    logic [NUM_W-1:0]     s_lhs, s_rhs;
    logic                 sv2_next;

    always_comb
    begin
        d_x6 = {2'b0, d1_reg, 2'b0} + {3'b0, d1_reg, 1'b0};
        case (sec1_reg)
            SEC_R:   t_raw = {4'b0, g1_reg} - {4'b0, b1_reg};
            SEC_G:   t_raw = {4'b0, b1_reg} - {4'b0, r1_reg} + {3'b0, d1_reg, 1'b0};
            default: t_raw = {4'b0, r1_reg} - {4'b0, g1_reg} + {2'b0, d1_reg, 2'b0};
        endcase
        // negative hue wraps by a full turn
        t_adj    = t_raw[11] ? t_raw + d_x6 : t_raw;
        s_lhs    = NUM_W'(d1_reg) * NUM_W'(S_NUM);
        s_rhs    = NUM_W'(max1_reg) * NUM_W'(S_DEN);
        sv2_next = (s_lhs >= s_rhs) && (max1_reg >= SV_MIN) && (d1_reg != '0);
    end

    // stage 3: hue numerator and band limits scaled by 2d
    metric_t metric_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            metric_reg <= '0;
        end
        else
        begin
            v1_reg                  <= in_valid;
            v2_reg                  <= v1_reg;
            metric_reg.valid        <= v2_reg;
            metric_reg.blue         <= b2_reg;
            metric_reg.green        <= g2_reg;
            metric_reg.red          <= r2_reg;
            metric_reg.sv_ok        <= sv2_reg;
            metric_reg.num          <= NUM_W'(t2_reg) * NUM_W'(H_SCALE) + NUM_W'(d2_reg);
            metric_reg.lim_blue_lo  <= NUM_W'(d2_reg) * NUM_W'(M_BLUE_LO);
            metric_reg.lim_blue_hi  <= NUM_W'(d2_reg) * NUM_W'(M_BLUE_HI);
            metric_reg.lim_red_hi   <= NUM_W'(d2_reg) * NUM_W'(M_RED_HI);
            metric_reg.lim_red_lo   <= NUM_W'(d2_reg) * NUM_W'(M_RED_LO);
            metric_reg.lim_green_lo <= NUM_W'(d2_reg) * NUM_W'(M_GREEN_LO);
            metric_reg.lim_green_hi <= NUM_W'(d2_reg) * NUM_W'(M_GREEN_HI);
        end
    end

    always_ff @(posedge clk)
    begin
        b1_reg   <= in_blue;
        g1_reg   <= in_green;
        r1_reg   <= in_red;
        max1_reg <= max1_next;
        d1_reg   <= max1_next - min1_next;
        sec1_reg <= sec1_next;

        b2_reg  <= b1_reg;
        g2_reg  <= g1_reg;
        r2_reg  <= r1_reg;
        d2_reg  <= d1_reg;
        t2_reg  <= t_adj;
        sv2_reg <= sv2_next;
    end

    assign metric = metric_reg;

endmodule

[hdl/hsv_color_key_mask_top.sv]
// a pixel taken with start comes out with done after the register stages below
// throughput: one pixel per cycle, busy is always low
// four register stages: min/max, hue offset and saturation test,
// hue products, band compare and output mux; the receiver cannot stall
// reset clears the stage valid bits and sets color_select to blue
module hsv_color_key_mask_top
    import hsvck_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  logic            color_select_we,
    input  logic [1:0]      color_select,
    input  logic [CH_W-1:0] in_blue,
    input  logic [CH_W-1:0] in_green,
    input  logic [CH_W-1:0] in_red,
    output logic            done,
    output logic [CH_W-1:0] out_blue,
    output logic [CH_W-1:0] out_green,
    output logic [CH_W-1:0] out_red,
    output logic            kept
);

    sel_t    color_select_reg;
    metric_t metric;
    logic    in_band;
    logic    keep_next;
    logic    done_reg, kept_reg;
    logic [CH_W-1:0] blue_reg, green_reg, red_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_select_reg <= SEL_BLUE;
        end
        else if (color_select_we)
        begin
            color_select_reg <= sel_t'(color_select);
        end
    end

    hsvck_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .in_blue  (in_blue),
        .in_green (in_green),
        .in_red   (in_red),
        .metric   (metric)
    );

    // hue of 180 wraps to 0, which the red band covers either way
    always_comb
    begin
        unique case (color_select_reg)
            SEL_BLUE:  in_band = (metric.num >= metric.lim_blue_lo)
                                 && (metric.num < metric.lim_blue_hi);
            SEL_RED:   in_band = (metric.num < metric.lim_red_hi)
                                 || (metric.num >= metric.lim_red_lo);
            SEL_GREEN: in_band = (metric.num >= metric.lim_green_lo)
                                 && (metric.num < metric.lim_green_hi);
            default:   in_band = 1'b0;
        endcase
        keep_next = metric.sv_ok && in_band;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= metric.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        kept_reg  <= keep_next;
        blue_reg  <= keep_next ? metric.blue  : WHITE;
        green_reg <= keep_next ? metric.green : WHITE;
        red_reg   <= keep_next ? metric.red   : WHITE;
    end

    assign done      = done_reg;
    assign kept      = kept_reg;
    assign out_blue  = blue_reg;
    assign out_green = green_reg;
    assign out_red   = red_reg;

endmodule

[bench/tb_hsv_color_key_mask_top.sv]
module tb_hsv_color_key_mask_top;
    import hsvck_pkg::*;

    typedef struct {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       kept;
    } key_result_t;

    class key_scoreboard;
        sel_t        sel;
        key_result_t awaited[$];
        int          errors;

        function new();
            sel = SEL_BLUE;
            errors = 0;
        endfunction

        function void set_select(sel_t value);
            sel = value;
        endfunction

        function bit hue_in_band(int h);
            case (sel)
                SEL_BLUE:  return h >= 85 && h <= 130;
                SEL_RED:   return h <= 10 || (h >= 160 && h <= 180);
                SEL_GREEN: return h >= 40 && h <= 84;
                default:   return 1'b0;
            endcase
        endfunction

        function key_result_t key_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
            int          bi, gi, ri, v, mn, d, s, h, t;
            key_result_t res;
            bi = int'(b);
            gi = int'(g);
            ri = int'(r);
            v = bi;
            mn = bi;
            if (gi > v) v = gi;
            if (ri > v) v = ri;
            if (gi < mn) mn = gi;
            if (ri < mn) mn = ri;
            d = v - mn;
            s = 0;
            h = 0;
            if (v != 0)
                s = (510 * d + v) / (2 * v);
            if (d != 0)
            begin
                // red sector wins ties, then green
                if (v == ri)
                    t = gi - bi;
                else if (v == gi)
                    t = bi - ri + 2 * d;
                else
                    t = ri - gi + 4 * d;
                if (t < 0)
                    t += 6 * d;
                h = (60 * t + d) / (2 * d);
                if (h >= 180)
                    h -= 180;
            end
            res.kept = (s >= 50) && (v >= 50) && hue_in_band(h);
            res.blue = res.kept ? b : 8'hFF;
            res.green = res.kept ? g : 8'hFF;
            res.red = res.kept ? r : 8'hFF;
            return res;
        endfunction

        function void note_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
            awaited.push_back(key_pixel(b, g, r));
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic k);
            key_result_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat, expected none actual b=%0d g=%0d r=%0d kept=%0d",
                         $time, b, g, r, k);
                return;
            end
            want = awaited.pop_front();
            compare_field("out_blue", int'(want.blue), int'(b));
            compare_field("out_green", int'(want.green), int'(g));
            compare_field("out_red", int'(want.red), int'(r));
            compare_field("kept", int'(want.kept), int'(k));
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    logic            color_select_we;
    logic [1:0]      color_select;
    logic [CH_W-1:0] in_blue;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_red;
    logic            done;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_red;
    logic            kept;

    key_scoreboard board;

    hsv_color_key_mask_top uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .color_select_we (color_select_we),
        .color_select    (color_select),
        .in_blue         (in_blue),
        .in_green        (in_green),
        .in_red          (in_red),
        .done            (done),
        .out_blue        (out_blue),
        .out_green       (out_green),
        .out_red         (out_red),
        .kept            (kept)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result(out_blue, out_green, out_red, kept);
    end

    task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
        start <= 1'b1;
        in_blue <= b;
        in_green <= g;
        in_red <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_pixel(b, g, r);
    endtask

    task automatic drain_pixels();
        start <= 1'b0;
        while (board.awaited.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_select(input sel_t value);
        color_select_we <= 1'b1;
        color_select <= value;
        @(posedge clk);
        color_select_we <= 1'b0;
        board.set_select(value);
    endtask

    // mix of uniform pixels and pixels built from max/mid/min so that
    // saturation, value and hue land near the band edges
    task automatic pick_pixel(output logic [7:0] b, output logic [7:0] g, output logic [7:0] r);
        int hi, lo, mid, kind;
        kind = $urandom_range(0, 2);
        if (kind == 0)
        begin
            b = 8'($urandom);
            g = 8'($urandom);
            r = 8'($urandom);
        end
        else
        begin
            hi = (kind == 1) ? $urandom_range(40, 255) : $urandom_range(0, 70);
            lo = $urandom_range(0, hi);
            mid = $urandom_range(lo, hi);
            case ($urandom_range(0, 5))
                0: begin b = 8'(hi);  g = 8'(mid); r = 8'(lo);  end
                1: begin b = 8'(hi);  g = 8'(lo);  r = 8'(mid); end
                2: begin b = 8'(mid); g = 8'(hi);  r = 8'(lo);  end
                3: begin b = 8'(lo);  g = 8'(hi);  r = 8'(mid); end
                4: begin b = 8'(mid); g = 8'(lo);  r = 8'(hi);  end
                default: begin b = 8'(lo); g = 8'(mid); r = 8'(hi); end
            endcase
        end
    endtask

    initial
    begin
        sel_t       dir_sel[4] = '{SEL_BLUE, SEL_RED, SEL_GREEN, SEL_NONE};
        sel_t       phase_sel[8] = '{SEL_RED, SEL_BLUE, SEL_GREEN, SEL_NONE,
                                     SEL_GREEN, SEL_RED, SEL_NONE, SEL_BLUE};
        int         idle_pct[4] = '{0, 58, 0, 24};
        // black, white, gray, pure blue, pure green, red whose hue wraps at 180
        logic [7:0] dir_px[6][3] = '{'{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255},
                                     '{8'd128, 8'd128, 8'd128}, '{8'd255, 8'd0, 8'd0},
                                     '{8'd0, 8'd255, 8'd0}, '{8'd1, 8'd0, 8'd255}};
        logic [7:0] b, g, r;
        board = new();
        rst_n <= 1'b0;
        start <= 1'b0;
        color_select_we <= 1'b0;
        color_select <= SEL_BLUE;
        in_blue <= '0;
        in_green <= '0;
        in_red <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_sel[i])
        begin
            write_select(dir_sel[i]);
            foreach (dir_px[j])
                send_pixel(dir_px[j][0], dir_px[j][1], dir_px[j][2]);
            drain_pixels();
        end

        foreach (phase_sel[p])
        begin
            write_select(phase_sel[p]);
            repeat (66)
            begin
                pick_pixel(b, g, r);
                send_pixel(b, g, r);
                if ($urandom_range(1, 100) <= idle_pct[p % 4])
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
            end
            drain_pixels();
        end

        // catch any extra beat after the pipeline empties
        repeat (10) @(posedge clk);
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
hdl/hsvck_pkg.sv
hdl/hsvck_core.sv
hdl/hsv_color_key_mask_top.sv
bench/tb_hsv_color_key_mask_top.sv
